// ===== rtl/ir_mwd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the IR median wall detector: widths, register map, reset values
// and the word, config and flag types. No dependencies.
package ir_mwd_pkg;

  localparam int CHANNELS     = 8;
  localparam int DIST_BITS    = 12;
  localparam int WINDOW_DEF   = 3;
  localparam int COUNT_BITS   = 5;
  localparam int OUTLIER_BITS = 4;
  localparam int APB_DATA_W   = 32;
  localparam int REG_IDX_W    = 3;
  localparam int APB_ADDR_W   = REG_IDX_W + 2;

  typedef logic [DIST_BITS-1:0]    dist_t;
  typedef logic [OUTLIER_BITS-1:0] outlier_t;
  typedef logic [COUNT_BITS-1:0]   count_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRONT_MAX   = 3'd0,
    REG_FRONT_MIN   = 3'd1,
    REG_SIDE_MAX    = 3'd2,
    REG_CROSS_LEFT  = 3'd3,
    REG_CROSS_RIGHT = 3'd4,
    REG_OUTLIER_MIN = 3'd5
  } reg_idx_t;

  localparam dist_t    RST_FRONT_MAX   = 12'd320;  // 20.0 cm
  localparam dist_t    RST_FRONT_MIN   = 12'd96;   // 6.0 cm
  localparam dist_t    RST_SIDE_MAX    = 12'd320;  // 20.0 cm
  localparam dist_t    RST_CROSS_LEFT  = 12'd0;
  localparam dist_t    RST_CROSS_RIGHT = 12'd0;
  localparam outlier_t RST_OUTLIER_MIN = 4'd3;

  typedef struct packed {
    dist_t    front_max_dist;
    dist_t    front_min_dist;
    dist_t    side_max_dist;
    dist_t    cross_limit_left;
    dist_t    cross_limit_right;
    outlier_t outlier_minimum;
  } cfg_t;

  typedef struct packed {
    dist_t dist_ch0;
    dist_t dist_ch1;
    dist_t dist_ch2;
    dist_t dist_ch3;
    dist_t dist_ch4;
    dist_t dist_ch5;
    dist_t dist_ch6;
    dist_t dist_ch7;
    logic  rotating;
  } in_item_t;

  typedef struct packed {
    logic left_wall;
    logic right_wall;
    logic front_wall;
    logic crossed;
  } flags_t;

  typedef struct packed {
    dist_t med_ch0;
    dist_t med_ch1;
    dist_t med_ch2;
    dist_t med_ch3;
    dist_t med_ch4;
    dist_t med_ch5;
    dist_t med_ch6;
    dist_t med_ch7;
    logic  left_wall;
    logic  right_wall;
    logic  front_wall;
    logic  crossed;
  } out_item_t;

endpackage

// ===== rtl/ir_mwd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the scan words and the result words.
// Depends on ir_mwd_pkg.
interface ir_mwd_in_if import ir_mwd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ir_mwd_out_if import ir_mwd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ir_mwd_regs.sv =====
`timescale 1ns / 1ps
// APB register file holding the six detector limits.
// Depends on ir_mwd_pkg.
module ir_mwd_regs import ir_mwd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FRONT_MAX:   cfg_nxt.front_max_dist    = pwdata[DIST_BITS-1:0];
        REG_FRONT_MIN:   cfg_nxt.front_min_dist    = pwdata[DIST_BITS-1:0];
        REG_SIDE_MAX:    cfg_nxt.side_max_dist     = pwdata[DIST_BITS-1:0];
        REG_CROSS_LEFT:  cfg_nxt.cross_limit_left  = pwdata[DIST_BITS-1:0];
        REG_CROSS_RIGHT: cfg_nxt.cross_limit_right = pwdata[DIST_BITS-1:0];
        REG_OUTLIER_MIN: cfg_nxt.outlier_minimum   = pwdata[OUTLIER_BITS-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRONT_MAX:   prdata = APB_DATA_W'(cfg_r.front_max_dist);
      REG_FRONT_MIN:   prdata = APB_DATA_W'(cfg_r.front_min_dist);
      REG_SIDE_MAX:    prdata = APB_DATA_W'(cfg_r.side_max_dist);
      REG_CROSS_LEFT:  prdata = APB_DATA_W'(cfg_r.cross_limit_left);
      REG_CROSS_RIGHT: prdata = APB_DATA_W'(cfg_r.cross_limit_right);
      REG_OUTLIER_MIN: prdata = APB_DATA_W'(cfg_r.outlier_minimum);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.front_max_dist    <= RST_FRONT_MAX;
      cfg_r.front_min_dist    <= RST_FRONT_MIN;
      cfg_r.side_max_dist     <= RST_SIDE_MAX;
      cfg_r.cross_limit_left  <= RST_CROSS_LEFT;
      cfg_r.cross_limit_right <= RST_CROSS_RIGHT;
      cfg_r.outlier_minimum   <= RST_OUTLIER_MIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/ir_mwd_median.sv =====
`timescale 1ns / 1ps
// One channel: shift line of previous samples and a rank-select median over
// the window. Depends on ir_mwd_pkg.
module ir_mwd_median import ir_mwd_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  dist_t sample,
  output dist_t med
);

  localparam int HIST = WINDOW - 1;
  localparam int MID  = (WINDOW - 1) / 2;
  localparam int CW   = $clog2(WINDOW);

  dist_t          hist_r [HIST];
  dist_t          win    [WINDOW];
  logic [CW-1:0]  rank   [WINDOW];
  logic [WINDOW-1:0] pick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HIST; k++) hist_r[k] <= '0;
    end else if (shift_en) begin
      hist_r[0] <= sample;
      for (int k = 1; k < HIST; k++) hist_r[k] <= hist_r[k-1];
    end
  end

  // rank with ties broken by position, so exactly one element sits at MID
  always_comb begin
    win[0] = sample;
    for (int k = 0; k < HIST; k++) win[k+1] = hist_r[k];
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i && (win[j] < win[i] || (win[j] == win[i] && j < i)))
          rank[i] = rank[i] + CW'(1);
      end
      pick[i] = (rank[i] == CW'(MID));
    end
    med = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (pick[i]) med = med | win[i];
    end
  end

endmodule

// ===== rtl/ir_mwd_detect.sv =====
`timescale 1ns / 1ps
// Wall flags from the medians and the debounce counter for the crossed pulse.
// Depends on ir_mwd_pkg.
module ir_mwd_detect import ir_mwd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   step,
  input  logic   rotating,
  input  cfg_t   cfg,
  input  dist_t  med [CHANNELS],
  output flags_t flags
);

  count_t cross_count_r;
  count_t cross_count_nxt;
  count_t count_inc;
  logic   cond;

  assign count_inc = cross_count_r + COUNT_BITS'(1);

  always_comb begin
    cond = (med[6] < cfg.cross_limit_left || med[7] < cfg.cross_limit_right) &&
           med[0] > cfg.front_max_dist && med[1] > cfg.front_max_dist;

    flags.left_wall  = med[2] < cfg.side_max_dist && med[3] < cfg.side_max_dist;
    flags.right_wall = med[4] < cfg.side_max_dist && med[5] < cfg.side_max_dist;
    flags.front_wall = med[0] < cfg.front_min_dist || med[1] < cfg.front_min_dist;
    flags.crossed    = 1'b0;
    cross_count_nxt  = '0;
    if (cond && !rotating) begin
      if (count_inc > COUNT_BITS'(cfg.outlier_minimum)) begin
        flags.crossed = 1'b1;
      end else begin
        cross_count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cross_count_r <= '0;
    end else if (step) begin
      cross_count_r <= cross_count_nxt;
    end
  end

endmodule

// ===== rtl/ir_median_wall_detector.sv =====
`timescale 1ns / 1ps
// IR median wall detector. Takes one scan word of eight 12-bit distances per
// clock unless stalled and returns one result word per scan: the median over
// the last WINDOW samples of each channel, left/right/front wall flags and a
// debounced crossed pulse. Sustained rate is one word per cycle while
// out.ready stays high. A word goes from the input register through the
// median/compare logic into the output register; a stalled output holds its
// word while one more scan waits in the input register. History starts at zero
// after reset. The user must write limits over APB at byte address 4*i only
// while the block is idle; nothing enforces this. Depends on ir_mwd_pkg, the
// stream interfaces, ir_mwd_regs, ir_mwd_median and ir_mwd_detect.
module ir_median_wall_detector import ir_mwd_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ir_mwd_in_if.sink             in_if,
  ir_mwd_out_if.source          out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t      cfg;
  logic      s0_valid_r;
  in_item_t  s0_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;
  logic      out_free;
  logic      advance;
  logic      in_fire;
  dist_t     samples [CHANNELS];
  dist_t     med     [CHANNELS];
  flags_t    flags;

  assign out_free     = !out_valid_r || out_if.ready;
  assign advance      = s0_valid_r && out_free;
  assign in_if.ready  = !s0_valid_r || out_free;
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  ir_mwd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign samples[0] = s0_data_r.dist_ch0;
  assign samples[1] = s0_data_r.dist_ch1;
  assign samples[2] = s0_data_r.dist_ch2;
  assign samples[3] = s0_data_r.dist_ch3;
  assign samples[4] = s0_data_r.dist_ch4;
  assign samples[5] = s0_data_r.dist_ch5;
  assign samples[6] = s0_data_r.dist_ch6;
  assign samples[7] = s0_data_r.dist_ch7;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    ir_mwd_median #(.WINDOW(WINDOW)) u_median (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (advance),
      .sample   (samples[c]),
      .med      (med[c])
    );
  end

  ir_mwd_detect u_detect (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .rotating (s0_data_r.rotating),
    .cfg      (cfg),
    .med      (med),
    .flags    (flags)
  );

  always_comb begin
    out_data_nxt.med_ch0    = med[0];
    out_data_nxt.med_ch1    = med[1];
    out_data_nxt.med_ch2    = med[2];
    out_data_nxt.med_ch3    = med[3];
    out_data_nxt.med_ch4    = med[4];
    out_data_nxt.med_ch5    = med[5];
    out_data_nxt.med_ch6    = med[6];
    out_data_nxt.med_ch7    = med[7];
    out_data_nxt.left_wall  = flags.left_wall;
    out_data_nxt.right_wall = flags.right_wall;
    out_data_nxt.front_wall = flags.front_wall;
    out_data_nxt.crossed    = flags.crossed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) s0_valid_r <= in_if.valid;
      if (out_free) out_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s0_data_r <= in_if.data;
    if (advance) out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/ir_mwd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the IR median wall detector, bound to the top level.
// Depends on ir_mwd_pkg and ir_median_wall_detector.
module ir_mwd_checker import ir_mwd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      pready
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with the output register empty the input register always drains
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready dropped");

  // a word taken while the output stalls fills the pipe, so input ready then
  // follows output ready
  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && in_valid && in_ready |=> in_ready == out_ready)
    else $error("pipe accepted beyond its two registers");

endmodule

bind ir_median_wall_detector ir_mwd_checker u_ir_mwd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data),
  .pready    (pready)
);
